@@ src/mmp2_pkg.sv @@
`default_nettype none
package mmp2_pkg;

  localparam int unsigned ENTRY_W = 30;
  localparam int unsigned EXP_W   = 63;
  localparam int unsigned CELLS   = 4;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [ENTRY_W-1:0] PRIME = 30'd1000000007;

  localparam logic [ENTRY_W-1:0] RST_E00 = 30'd19;
  localparam logic [ENTRY_W-1:0] RST_E01 = 30'd7;
  localparam logic [ENTRY_W-1:0] RST_E10 = 30'd6;
  localparam logic [ENTRY_W-1:0] RST_E11 = 30'd20;

  localparam logic [CFG_IDX_W-1:0] REG_E00 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_E01 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_E10 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_E11 = 8'd3;

  // sequencer states
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_RED  = 6'b000100,
    ST_ACC  = 6'b001000,
    ST_NEXT = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] e00;
    logic [ENTRY_W-1:0] e01;
    logic [ENTRY_W-1:0] e10;
    logic [ENTRY_W-1:0] e11;
  } mat_t;

endpackage
`default_nettype wire

@@ src/modular_matrix_power_2x2.sv @@
// Sequence: after the accepting edge ST_NEXT checks the exponent; for each bit, a set bit
//   first multiplies acc by base, then base is squared and the exponent shifted; at zero, ST_OUT.
// Throughput: one transaction in flight; the next can be taken in the cycle that out_tvalid rises.
//   A matrix multiply is 8 products through ST_MUL, ST_RED and ST_ACC on one shared 30x30
//   multiplier, Barrett-reduced; a result held off by out_tready stalls the next one in its last step.
// Reset: synchronous active-low rst_n clears control and restores the matrix to 19, 7, 6, 20.
`default_nettype none
module modular_matrix_power_2x2 (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [63:0]   in_tdata,   // [62:0] exponent, [63] zero
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [119:0]       out_tdata,  // [29:0] r0c0, [59:30] r0c1, [89:60] r1c0, [119:90] r1c1
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [7:0]    cfg_index,
  input  wire logic [31:0]   cfg_data
);

  localparam int unsigned W = mmp2_pkg::ENTRY_W;
  localparam logic [W-1:0] PRIMEX = mmp2_pkg::PRIME;

  // configuration registers, raw 30 bits as written
  logic [W-1:0] cfg_e_r [mmp2_pkg::CELLS];

  mmp2_pkg::state_t state_r, state_nxt;

  logic [W-1:0] acc_r  [mmp2_pkg::CELLS];   // accumulated product
  logic [W-1:0] base_r [mmp2_pkg::CELLS];   // squared base
  logic [W-1:0] tmp_r  [mmp2_pkg::CELLS];   // results of current multiply
  logic [mmp2_pkg::EXP_W-1:0] exp_r;

  // step of current matrix multiply: out cell (2 bits) and k (1 bit)
  logic [mmp2_pkg::IDX_W-1:0] cell_r;
  logic                       k_r;
  logic                       sq_r;         // 1: squaring base, 0: acc*base
  logic [W-1:0]               sum_r;        // running dot product, reduced
  logic [2*W-1:0]             prod_r;
  logic [W-1:0]               red_r;        // reduced product

  logic [W-1:0] out_q_r [mmp2_pkg::CELLS];
  logic         out_valid_r;
  logic         out_free;                   // output register can take a new result

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == mmp2_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_q_r[3], out_q_r[2], out_q_r[1], out_q_r[0]};
  assign out_free   = !out_valid_r || out_tready;

  // operand selection for shared multiplier
  logic [mmp2_pkg::IDX_W-1:0] a_idx, b_idx;
  logic [W-1:0] op_a, op_b;
  always_comb begin
    a_idx = {cell_r[1], k_r};
    b_idx = {k_r, cell_r[0]};
    op_a  = sq_r ? base_r[a_idx] : acc_r[a_idx];
    op_b  = base_r[b_idx];
  end

  // Barrett reduction of a product below P*P: q = ((x >> 29) * mu) >> 31, mu = floor(2^60 / P)
  // q undershoots by at most two; fixed with two compare-subtract steps
  localparam logic [60:0] MU = 61'd1152921496;   // floor(2^60 / P)
  logic [W+1:0] rem;
  logic [W+1:0] rem1;
  logic [W-1:0] red_val;
  // multi-cycle reduction: stage register for quotient estimate
  logic [31:0]  q_r;
  logic [1:0]   rstep_r;
  always_comb begin
    rem  = (W+2)'(prod_r - 60'(q_r) * 60'(PRIMEX));
    rem1 = (rem >= (W+2)'(PRIMEX)) ? rem - (W+2)'(PRIMEX) : rem;
    red_val = (rem1 >= (W+2)'(PRIMEX)) ? W'(rem1 - (W+2)'(PRIMEX)) : W'(rem1);
  end

  // add of dot product terms
  logic [W:0] s_add;
  logic [W-1:0] s_mod;
  always_comb begin
    s_add = {1'b0, sum_r} + {1'b0, red_r};
    s_mod = (s_add >= {1'b0, PRIMEX}) ? W'(s_add - {1'b0, PRIMEX}) : W'(s_add);
  end

  logic last_cell, last_k;
  assign last_k    = k_r;
  assign last_cell = (cell_r == 2'd3);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mmp2_pkg::ST_IDLE: if (in_tvalid && in_tready) state_nxt = mmp2_pkg::ST_NEXT;
      mmp2_pkg::ST_NEXT: state_nxt = (exp_r == '0) ? mmp2_pkg::ST_OUT : mmp2_pkg::ST_MUL;
      mmp2_pkg::ST_MUL:  state_nxt = mmp2_pkg::ST_RED;
      mmp2_pkg::ST_RED:  state_nxt = (rstep_r == 2'd1) ? mmp2_pkg::ST_ACC : mmp2_pkg::ST_RED;
      mmp2_pkg::ST_ACC: begin
        if (last_k && last_cell && sq_r) state_nxt = mmp2_pkg::ST_NEXT;
        else                             state_nxt = mmp2_pkg::ST_MUL;
      end
      // wait here while the previous result is still held
      mmp2_pkg::ST_OUT:  state_nxt = out_free ? mmp2_pkg::ST_IDLE : mmp2_pkg::ST_OUT;
      default:           state_nxt = mmp2_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mmp2_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      cfg_e_r[0]  <= mmp2_pkg::RST_E00;
      cfg_e_r[1]  <= mmp2_pkg::RST_E01;
      cfg_e_r[2]  <= mmp2_pkg::RST_E10;
      cfg_e_r[3]  <= mmp2_pkg::RST_E11;
      rstep_r     <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          mmp2_pkg::REG_E00: cfg_e_r[0] <= cfg_data[W-1:0];
          mmp2_pkg::REG_E01: cfg_e_r[1] <= cfg_data[W-1:0];
          mmp2_pkg::REG_E10: cfg_e_r[2] <= cfg_data[W-1:0];
          mmp2_pkg::REG_E11: cfg_e_r[3] <= cfg_data[W-1:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (state_r == mmp2_pkg::ST_OUT && out_free) out_valid_r <= 1'b1;
      if (state_r == mmp2_pkg::ST_MUL) rstep_r <= 2'd0;
      else if (state_r == mmp2_pkg::ST_RED) rstep_r <= rstep_r + 2'd1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      mmp2_pkg::ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          exp_r <= in_tdata[mmp2_pkg::EXP_W-1:0];
          for (int i = 0; i < 4; i++) begin
            acc_r[i]  <= (i == 0 || i == 3) ? W'(1) : W'(0);
            base_r[i] <= (cfg_e_r[i] >= PRIMEX) ? cfg_e_r[i] - PRIMEX : cfg_e_r[i];
          end
        end
      end
      mmp2_pkg::ST_NEXT: begin
        cell_r <= '0;
        k_r    <= 1'b0;
        sum_r  <= '0;
        sq_r   <= ~exp_r[0];
      end
      mmp2_pkg::ST_MUL: prod_r <= op_a * op_b;
      mmp2_pkg::ST_RED: begin
        // step 0: quotient estimate from top bits; step 1: fold
        if (rstep_r == 2'd0) q_r <= 32'((64'(prod_r[2*W-1:29]) * 64'(MU)) >> 31);
        else red_r <= red_val;
      end
      mmp2_pkg::ST_ACC: begin
        if (!k_r) begin
          sum_r <= s_mod;
          k_r   <= 1'b1;
        end else begin
          tmp_r[cell_r] <= s_mod;
          sum_r <= '0;
          k_r   <= 1'b0;
          cell_r <= cell_r + 2'd1;
          if (last_cell) begin
            if (sq_r) begin
              base_r[0] <= tmp_r[0]; base_r[1] <= tmp_r[1];
              base_r[2] <= tmp_r[2]; base_r[3] <= s_mod;
              exp_r <= exp_r >> 1;
            end else begin
              acc_r[0] <= tmp_r[0]; acc_r[1] <= tmp_r[1];
              acc_r[2] <= tmp_r[2]; acc_r[3] <= s_mod;
              sq_r <= 1'b1;
            end
          end
        end
      end
      mmp2_pkg::ST_OUT: begin
        if (out_free) begin
          for (int i = 0; i < 4; i++) out_q_r[i] <= acc_r[i];
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ src/mmp2_checker.sv @@
`default_nettype none
module mmp2_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [119:0] out_tdata
);
  // result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("result dropped");
  // entries stay below the prime
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[29:0] < mmp2_pkg::PRIME) && (out_tdata[59:30] < mmp2_pkg::PRIME)
                && (out_tdata[89:60] < mmp2_pkg::PRIME) && (out_tdata[119:90] < mmp2_pkg::PRIME))
    else $error("entry not reduced");
  // accepting an item drops ready
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("ready after accept");
endmodule

bind modular_matrix_power_2x2 mmp2_checker u_mmp2_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire

@@ dv/tb_modular_matrix_power_2x2.sv @@
`default_nettype none
module tb_modular_matrix_power_2x2;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned MOD_P = 64'd1000000007;
  // register indexes outside the matrix; writes there must be dropped
  localparam logic [mmp2_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd4;
  localparam logic [mmp2_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;
  localparam logic [62:0] EXP_MAX = {63{1'b1}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mmp2_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predictor copy of the four matrix registers, row-major
  logic [mmp2_pkg::ENTRY_W-1:0] matrix_regs [mmp2_pkg::CELLS];
  // expected power matrices, oldest first, packed like out_tdata
  logic [119:0] expected_powers [$];

  int unsigned errors = 0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_cfg = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned rx_hold_cycles = 0;

  always #5 clk = ~clk;

  modular_matrix_power_2x2 dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 2x2 product mod P, accumulating term by term as the hardware does
  function automatic void mat_mulmod(input longint unsigned a[mmp2_pkg::CELLS],
                                     input longint unsigned b[mmp2_pkg::CELLS],
                                     output longint unsigned y[mmp2_pkg::CELLS]);
    longint unsigned acc;
    for (int r = 0; r < 2; r++) begin
      for (int c = 0; c < 2; c++) begin
        acc = 0;
        for (int k = 0; k < 2; k++) begin
          acc = (acc + a[r*2+k] * b[k*2+c]) % MOD_P;
        end
        y[r*2+c] = acc;
      end
    end
  endfunction

  // M^e mod P by LSB-first square-and-multiply
  function automatic logic [119:0] matrix_power(input logic [62:0] e);
    longint unsigned acc[mmp2_pkg::CELLS];
    longint unsigned base[mmp2_pkg::CELLS];
    longint unsigned tmp[mmp2_pkg::CELLS];
    logic [62:0] rem;
    logic [119:0] packed_res;
    rem = e;
    for (int i = 0; i < mmp2_pkg::CELLS; i++) begin
      acc[i] = (i == 0 || i == 3) ? 1 : 0;
      base[i] = longint'(matrix_regs[i]) % MOD_P;
    end
    while (rem != 0) begin
      if (rem[0]) begin
        mat_mulmod(acc, base, tmp);
        acc = tmp;
      end
      mat_mulmod(base, base, tmp);
      base = tmp;
      rem = rem >> 1;
    end
    for (int i = 0; i < mmp2_pkg::CELLS; i++) packed_res[i*30 +: 30] = acc[i][29:0];
    return packed_res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    errors++;
  endtask

  // one input transaction; expectation queued at the accepting edge
  task automatic send_exponent(input logic [62:0] e);
    @(negedge clk);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, e};
    do @(posedge clk); while (!in_tready);
    expected_powers.push_back(matrix_power(e));
    n_items++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // wait until every queued result has been seen
  task automatic drain();
    release_input();
    while (expected_powers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // only called while idle
  task automatic write_reg(input logic [mmp2_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < mmp2_pkg::CELLS) matrix_regs[idx] = val[mmp2_pkg::ENTRY_W-1:0];
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_matrix(input logic [31:0] a, b, c, d);
    write_reg(mmp2_pkg::REG_E00, a);
    write_reg(mmp2_pkg::REG_E01, b);
    write_reg(mmp2_pkg::REG_E10, c);
    write_reg(mmp2_pkg::REG_E11, d);
  endtask

  // mostly short exponents to keep the run length sane, some full width
  function automatic logic [62:0] rand_exponent();
    logic [62:0] e;
    int unsigned len;
    e = 63'({$urandom, $urandom});
    if ($urandom_range(9) == 0) return e;
    len = $urandom_range(0, 24);
    return (len == 0) ? '0 : (e & ((63'd1 << len) - 1));
  endfunction

  // receiver: random idling plus an occasional long hold
  always @(negedge clk) begin
    if (rx_hold_cycles != 0) begin
      rx_hold_cycles <= rx_hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    logic [119:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (expected_powers.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_tdata));
      end else begin
        want = expected_powers.pop_front();
        for (int i = 0; i < mmp2_pkg::CELLS; i++) begin
          if (out_tdata[i*30 +: 30] !== want[i*30 +: 30])
            report_mismatch($sformatf("entry r%0dc%0d got %0d want %0d", i / 2, i % 2,
                                      out_tdata[i*30 +: 30], want[i*30 +: 30]));
        end
      end
    end
  end

  // reset matrix, exponent extremes
  task automatic test_reset_matrix();
    send_exponent('0);
    send_exponent(63'd1);
    send_exponent(63'd2);
    send_exponent(63'd3);
    send_exponent(EXP_MAX);
    send_exponent(63'd1 << 62);
    send_exponent(63'h5555_5555_5555_5555);
    drain();
  endtask

  // register extremes, unreduced values, dropped indexes
  task automatic test_register_extremes();
    write_matrix('0, '0, '0, '0);
    send_exponent('0);
    send_exponent(63'd5);
    drain();
    write_matrix(32'(MOD_P - 1), 32'(MOD_P - 1), 32'(MOD_P - 1), 32'(MOD_P - 1));
    send_exponent(63'd1);
    send_exponent(EXP_MAX);
    drain();
    // at or above P: kept raw, reduced on use; upper cfg_data bits dropped
    write_matrix(32'(MOD_P), 32'hFFFF_FFFF, 32'h3FFF_FFFF, 32'(MOD_P + 1) | 32'hC000_0000);
    send_exponent(63'd1);
    send_exponent(63'd7);
    send_exponent(63'h2AAA_AAAA_AAAA_AAAA);
    drain();
    // writes to nonexistent registers must not disturb the matrix
    write_matrix(32'd1, 32'd1, 32'd1, 32'd0);
    write_reg(REG_UNUSED_LO, 32'd12345);
    write_reg(REG_UNUSED_HI, 32'hFFFF_FFFF);
    send_exponent(63'd10);
    send_exponent(63'd90);
    drain();
  endtask

  task automatic random_phase(input int unsigned tx_pct, rx_pct, count);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    write_matrix($urandom_range(0, 32'h3FFF_FFFF), $urandom, $urandom,
                 $urandom_range(0, 32'(MOD_P - 1)));
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        drain();
        write_matrix($urandom, $urandom, $urandom, $urandom);
      end
      send_exponent(rand_exponent());
    end
    drain();
  endtask

  // output held off long enough that the block must stall its input
  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    @(negedge clk);
    rx_hold_cycles = 3000;
    for (int i = 0; i < 8; i++) send_exponent(63'($urandom_range(0, 255)));
    drain();
  endtask

  initial begin
    #100ms;
    $display("timeout after %0d transactions, %0d results", n_items, n_results);
    $display("FAIL modular_matrix_power_2x2");
    $finish;
  end

  initial begin
    matrix_regs[0] = mmp2_pkg::RST_E00;
    matrix_regs[1] = mmp2_pkg::RST_E01;
    matrix_regs[2] = mmp2_pkg::RST_E10;
    matrix_regs[3] = mmp2_pkg::RST_E11;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_matrix();
    test_register_extremes();
    random_phase(21, 83, 90);
    random_phase(83, 21, 90);
    random_phase(0, 0, 90);
    test_output_backpressure();

    repeat (50) @(posedge clk);
    $display("covered %0d exponents, %0d results, %0d register writes", n_items,
             n_results, n_cfg);
    $display("incl. zero/max exponents, unreduced and dropped writes, long output stall");
    if (errors == 0) begin
      $display("PASS modular_matrix_power_2x2");
    end else begin
      $display("FAIL modular_matrix_power_2x2");
    end
    $finish;
  end
endmodule
`default_nettype wire
